@@ src/ncs_pkg.sv @@
// Shared types, opcodes and helpers for the NAND command cycle sequencer.
`timescale 1ns / 1ps

package ncs_pkg;

  localparam int NumCycles = 8;
  localparam int IdxW      = $clog2(NumCycles);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 15;

  localparam logic [CfgIdxW-1:0] RegBusWidth16   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegExtraRow     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPageBytes    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHasReadyPin  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFixedDelayUs = 3'd4;

  localparam logic [7:0] OpRead0       = 8'h00;
  localparam logic [7:0] OpRndOut      = 8'h05;
  localparam logic [7:0] OpPageProg    = 8'h10;
  localparam logic [7:0] OpCachedProg  = 8'h15;
  localparam logic [7:0] OpReadStart   = 8'h30;
  localparam logic [7:0] OpReadOob     = 8'h50;
  localparam logic [7:0] OpErase1      = 8'h60;
  localparam logic [7:0] OpStatus      = 8'h70;
  localparam logic [7:0] OpSeqIn       = 8'h80;
  localparam logic [7:0] OpRndIn       = 8'h85;
  localparam logic [7:0] OpReadId      = 8'h90;
  localparam logic [7:0] OpErase2      = 8'hD0;
  localparam logic [7:0] OpRndOutStart = 8'hE0;
  localparam logic [7:0] OpParam       = 8'hEC;
  localparam logic [7:0] OpGetFeat     = 8'hEE;
  localparam logic [7:0] OpSetFeat     = 8'hEF;
  localparam logic [7:0] OpReset       = 8'hFF;

  typedef enum logic [1:0] {
    KindCmd   = 2'd0,
    KindAddr  = 2'd1,
    KindDelay = 2'd2,
    KindWait  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        has_column;
    logic [15:0] column_address;
    logic        has_page;
    logic [23:0] page_address;
  } in_t;

  typedef struct packed {
    kind_t      cycle_kind;
    logic [7:0] cycle_byte;
    logic       clear_ready;
    logic       last_cycle;
  } out_t;

  typedef struct packed {
    logic        bus_width_16;
    logic        extra_row_cycle;
    logic [14:0] page_data_bytes;
    logic        has_ready_pin;
    logic [7:0]  fixed_delay_us;
  } cfg_t;

  typedef struct packed {
    out_t [NumCycles-1:0] cycles;
    logic [IdxW-1:0]      last_idx;
  } seq_t;

  function automatic out_t make_cycle(kind_t kind, logic [7:0] byte_val, logic clr);
    out_t c;
    c.cycle_kind  = kind;
    c.cycle_byte  = byte_val;
    c.clear_ready = clr;
    c.last_cycle  = 1'b0;
    return c;
  endfunction

  function automatic out_t make_latch(logic [7:0] op);
    return make_cycle(KindCmd, op,
                      (op != OpStatus) && (op != OpReadId) && (op != OpReset));
  endfunction

endpackage

@@ src/nand_command_cycle_sequencer.sv @@
// Top level of the NAND command cycle sequencer: registers, decode and emitter.
`timescale 1ns / 1ps

// Each accepted request is expanded at once into its bus-cycle list (one
// command latch, optional column and page address bytes, then, by opcode,
// a tail latch and/or a wait-ready or fixed-delay cycle) and those cycles
// leave one per clock, unless out_stall holds them, through a single output
// register. A request has 1 to 8 bus cycles, and the next request is
// taken in the clock in which the last cycle of the current one moves into
// the output register, so back-to-back requests leave no gap on the output.
// Configuration registers are written through the cfg_ channel, always
// ready, and must only be changed while no request is in flight.

module nand_command_cycle_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ncs_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ncs_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ncs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ncs_pkg::CfgDataW-1:0]  cfg_data
);

  ncs_pkg::cfg_t cfg_r;
  ncs_pkg::seq_t seq;
  logic          busy;
  logic          done;
  logic          load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_width_16    <= 1'b0;
      cfg_r.extra_row_cycle <= 1'b0;
      cfg_r.page_data_bytes <= 15'd2048;
      cfg_r.has_ready_pin   <= 1'b1;
      cfg_r.fixed_delay_us  <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ncs_pkg::RegBusWidth16:   cfg_r.bus_width_16    <= cfg_data[0];
        ncs_pkg::RegExtraRow:     cfg_r.extra_row_cycle <= cfg_data[0];
        ncs_pkg::RegPageBytes:    cfg_r.page_data_bytes <= cfg_data;
        ncs_pkg::RegHasReadyPin:  cfg_r.has_ready_pin   <= cfg_data[0];
        ncs_pkg::RegFixedDelayUs: cfg_r.fixed_delay_us  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy && !done;
  assign load     = in_valid && !in_stall;

  ncs_decode u_decode (
    .req (in_data),
    .cfg (cfg_r),
    .seq (seq)
  );

  ncs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .seq       (seq),
    .busy      (busy),
    .done      (done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/ncs_decode.sv @@
// Expands one command request into its list of bus cycles.
`timescale 1ns / 1ps

module ncs_decode (
  input  ncs_pkg::in_t  req,
  input  ncs_pkg::cfg_t cfg,
  output ncs_pkg::seq_t seq
);

  localparam int IdxCnt = ncs_pkg::IdxW;

  always_comb begin
    logic [7:0]  op;
    logic [16:0] col;
    logic [15:0] col_bus;
    logic        wide_op;
    logic [IdxCnt:0] n;
    logic [IdxCnt:0] n_m1;

    op  = req.opcode;
    col = {1'b0, req.column_address};
    if (op == ncs_pkg::OpReadOob) begin
      col = {1'b0, req.column_address} + {2'b00, cfg.page_data_bytes};
      op  = ncs_pkg::OpRead0;
    end
    wide_op = (op != ncs_pkg::OpReadId) && (op != ncs_pkg::OpParam) &&
              (op != ncs_pkg::OpGetFeat) && (op != ncs_pkg::OpSetFeat);
    col_bus = (cfg.bus_width_16 && wide_op) ? col[16:1] : col[15:0];

    seq.cycles = '0;
    n = '0;

    seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_latch(op);
    n = n + 1'b1;

    if (req.has_column) begin
      seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_cycle(ncs_pkg::KindAddr, col_bus[7:0], 1'b0);
      n = n + 1'b1;
      seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_cycle(ncs_pkg::KindAddr, col_bus[15:8], 1'b0);
      n = n + 1'b1;
    end

    if (req.has_page) begin
      seq.cycles[n[IdxCnt-1:0]] =
        ncs_pkg::make_cycle(ncs_pkg::KindAddr, req.page_address[7:0], 1'b0);
      n = n + 1'b1;
      seq.cycles[n[IdxCnt-1:0]] =
        ncs_pkg::make_cycle(ncs_pkg::KindAddr, req.page_address[15:8], 1'b0);
      n = n + 1'b1;
      if (cfg.extra_row_cycle) begin
        seq.cycles[n[IdxCnt-1:0]] =
          ncs_pkg::make_cycle(ncs_pkg::KindAddr, req.page_address[23:16], 1'b0);
        n = n + 1'b1;
      end
    end

    unique case (op) inside
      ncs_pkg::OpCachedProg, ncs_pkg::OpPageProg, ncs_pkg::OpErase1,
      ncs_pkg::OpErase2, ncs_pkg::OpSeqIn, ncs_pkg::OpRndIn,
      ncs_pkg::OpStatus: begin
      end
      ncs_pkg::OpReset: begin
        seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_cycle(ncs_pkg::KindWait, 8'h00, 1'b0);
        n = n + 1'b1;
      end
      ncs_pkg::OpRndOut: begin
        seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_latch(ncs_pkg::OpRndOutStart);
        n = n + 1'b1;
      end
      default: begin
        if (op == ncs_pkg::OpRead0) begin
          seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_latch(ncs_pkg::OpReadStart);
          n = n + 1'b1;
        end
        if (cfg.has_ready_pin) begin
          seq.cycles[n[IdxCnt-1:0]] = ncs_pkg::make_cycle(ncs_pkg::KindWait, 8'h00, 1'b0);
        end else begin
          seq.cycles[n[IdxCnt-1:0]] =
            ncs_pkg::make_cycle(ncs_pkg::KindDelay, cfg.fixed_delay_us, 1'b0);
        end
        n = n + 1'b1;
      end
    endcase

    n_m1 = n - 1'b1;
    seq.last_idx = n_m1[IdxCnt-1:0];
    seq.cycles[seq.last_idx].last_cycle = 1'b1;
  end

endmodule

@@ src/ncs_emit.sv @@
// Holds one expanded request and sends its cycles through the output register.
`timescale 1ns / 1ps

module ncs_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ncs_pkg::seq_t seq,
  output logic          busy,
  output logic          done,
  output logic          out_valid,
  input  logic          out_stall,
  output ncs_pkg::out_t out_data
);

  ncs_pkg::out_t [ncs_pkg::NumCycles-1:0] list_r;
  logic [ncs_pkg::IdxW-1:0] last_idx_r;
  logic [ncs_pkg::IdxW-1:0] idx_r;
  logic                     full_r;
  logic                     out_valid_r;
  ncs_pkg::out_t            out_data_r;
  logic                     adv;

  assign adv  = full_r && (!out_valid_r || !out_stall);
  assign done = adv && (idx_r == last_idx_r);
  assign busy = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        full_r <= 1'b1;
        idx_r  <= '0;
      end else if (done) begin
        full_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r     <= seq.cycles;
      last_idx_r <= seq.last_idx;
    end
    if (adv) begin
      out_data_r <= list_r[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
